### src/wss_pkg.sv
// Shared constants and types for the wildcard substring search block.
package wss_pkg;

    localparam int NEEDLE_MAX    = 16;
    localparam int HAYSTACK_MAX  = 256;

    localparam int BYTE_W        = 8;
    localparam int CFG_LANES     = 16;
    localparam int LANES         = (NEEDLE_MAX < CFG_LANES) ? NEEDLE_MAX : CFG_LANES;
    localparam int LEN_W         = $clog2(LANES + 1);
    localparam int CFG_LEN_W     = 5;
    localparam int POS_W         = $clog2(HAYSTACK_MAX + 1);
    localparam int START_W       = 8;
    localparam int DIFF_W        = (POS_W > START_W) ? POS_W : START_W;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LO = 3'd0,
        REG_NEEDLE_HI = 3'd1,
        REG_NEEDLE_LEN = 3'd2,
        REG_WC_ENABLE = 3'd3,
        REG_WC_BYTE   = 3'd4
    } wss_reg_idx_t;

    // Per-cycle control broadcast along the cell row
    typedef struct packed {
        logic              step;
        logic              flush;
        logic [BYTE_W-1:0] hay;
        logic              wc_en;
        logic [BYTE_W-1:0] wc_byte;
    } wss_ctrl_t;

    // Result request, lowest bit first: found, match_start, too_long
    typedef struct packed {
        logic               too_long;
        logic [START_W-1:0] match_start;
        logic               found;
    } wss_result_t;

    localparam int RESULT_W = $bits(wss_result_t);

endpackage

### src/wss_cell.sv
// One lane of the shift-and row: compares its needle byte and holds one prefix bit.
module wss_cell
    import wss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  wss_ctrl_t         ctrl,
    input  logic [BYTE_W-1:0] lane_byte,
    input  logic              lane_used,
    input  logic              prev_bit,
    output logic              hit_next,
    output logic              bit_q
);

    logic bit_reg;
    logic bit_next;
    logic lane_match;

    assign lane_match = (lane_byte == ctrl.hay) || (ctrl.wc_en && (lane_byte == ctrl.wc_byte));
    assign hit_next   = prev_bit && lane_match && lane_used;

    always_comb begin
        bit_next = bit_reg;
        if (ctrl.step) begin
            bit_next = ctrl.flush ? 1'b0 : hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else begin
            bit_reg <= bit_next;
        end
    end

    assign bit_q = bit_reg;

endmodule

### src/wss_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module wss_out_buf
    import wss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  wss_result_t push_data,
    output logic        push_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output wss_result_t out_data
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    wss_result_t out_data_reg, out_data_next;
    wss_result_t skid_data_reg, skid_data_next;
    logic        pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_data_next = push_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                // hold the new request behind the stalled one
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("request pushed into full buffer");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && out_ready |=> !skid_valid_reg)
        else $error("skid entry not moved on pop");
`endif

endmodule

### src/wildcard_substring_search.sv
// Top level: config registers, shift-and cell row, string tracking and result buffer.
//
//  channel   | ports                          | contents
//  ----------+--------------------------------+------------------------------------------
//  input     | s_tvalid s_tready s_tdata s_tlast | haystack byte, last-byte mark on tlast
//  result    | m_tvalid m_tready m_tdata      | found, match_start, too_long
//  config    | cfg_wr_en cfg_wr_index cfg_wr_data | needle lo/hi, length, wildcard en/byte
//
// One haystack byte per cycle while s_tready is high; the compare and prefix shift happen
// in the cycle of acceptance. The result request is pushed into the buffer on the last byte.
// Two result entries are buffered; s_tready drops only while both are held by m_tready low.
// Synchronous active-low reset clears string state, buffer and config to defaults.
module wildcard_substring_search
    import wss_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] haystack_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] found, [8:1] match_start, [9] too_long
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    logic [CFG_DATA_W-1:0] needle_lo_reg, needle_hi_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  wc_en_reg;
    logic [BYTE_W-1:0]     wc_byte_reg;
    logic [CFG_LEN_W-1:0]  len_wr;
    logic [LEN_W-1:0]      len_clamped;

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  match_seen_reg, match_seen_next;
    logic [START_W-1:0]    first_start_reg, first_start_next;
    logic                  overflow_reg, overflow_next;

    logic                  accept;
    logic                  at_max;
    logic                  full_hit;
    logic [DIFF_W-1:0]     start_calc;
    logic [2*CFG_DATA_W-1:0] needle_vec;
    logic [LANES-1:0]      lane_used;
    logic [LANES-1:0]      lane_top;
    logic [LANES-1:0]      hit_vec;
    logic [LANES:0]        chain;
    logic                  buf_ready;
    wss_ctrl_t             ctrl;
    wss_result_t           result;
    wss_result_t           out_data;

    // Config writes; length 0 acts as 1, long lengths cap at the lane count
    assign len_wr = cfg_wr_data[CFG_LEN_W-1:0];

    always_comb begin
        if (len_wr == '0) begin
            len_clamped = LEN_W'(1);
        end else if (len_wr > CFG_LEN_W'(LANES)) begin
            len_clamped = LEN_W'(LANES);
        end else begin
            len_clamped = LEN_W'(len_wr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_lo_reg <= '0;
            needle_hi_reg <= '0;
            len_reg       <= LEN_W'(1);
            wc_en_reg     <= 1'b0;
            wc_byte_reg   <= BYTE_W'(63);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_NEEDLE_LO:  needle_lo_reg <= cfg_wr_data;
                REG_NEEDLE_HI:  needle_hi_reg <= cfg_wr_data;
                REG_NEEDLE_LEN: len_reg       <= len_clamped;
                REG_WC_ENABLE:  wc_en_reg     <= cfg_wr_data[0];
                REG_WC_BYTE:    wc_byte_reg   <= cfg_wr_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign needle_vec = {needle_hi_reg, needle_lo_reg};

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_used[i] = LEN_W'(i) < len_reg;
            lane_top[i]  = LEN_W'(i + 1) == len_reg;
        end
    end

    assign buf_ready = 1'b1 && s_tready;
    assign accept    = s_tvalid && buf_ready;
    assign at_max    = pos_reg == POS_W'(HAYSTACK_MAX);

    assign ctrl.step    = accept;
    assign ctrl.flush   = s_tlast || at_max;
    assign ctrl.hay     = s_tdata[BYTE_W-1:0];
    assign ctrl.wc_en   = wc_en_reg;
    assign ctrl.wc_byte = wc_byte_reg;

    // Lane 0 always sees an open prefix
    assign chain[0] = 1'b1;

    for (genvar g = 0; g < LANES; g++) begin : g_cell
        wss_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .lane_byte (needle_vec[BYTE_W*g +: BYTE_W]),
            .lane_used (lane_used[g]),
            .prev_bit  (chain[g]),
            .hit_next  (hit_vec[g]),
            .bit_q     (chain[g+1])
        );
    end

    assign full_hit   = |(hit_vec & lane_top) && !at_max;
    assign start_calc = DIFF_W'(pos_reg) - DIFF_W'(len_reg) + DIFF_W'(1);

    always_comb begin
        pos_next         = pos_reg;
        match_seen_next  = match_seen_reg;
        first_start_next = first_start_reg;
        overflow_next    = overflow_reg;
        if (accept) begin
            if (at_max) begin
                overflow_next = 1'b1;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                if (!match_seen_reg && full_hit) begin
                    match_seen_next  = 1'b1;
                    first_start_next = start_calc[START_W-1:0];
                end
            end
        end
    end

    assign result.found       = match_seen_next;
    assign result.match_start = match_seen_next ? first_start_next : '0;
    assign result.too_long    = overflow_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            match_seen_reg  <= 1'b0;
            first_start_reg <= '0;
            overflow_reg    <= 1'b0;
        end else if (accept && s_tlast) begin
            // drop per-string state once the result is issued
            pos_reg         <= '0;
            match_seen_reg  <= 1'b0;
            first_start_reg <= '0;
            overflow_reg    <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            match_seen_reg  <= match_seen_next;
            first_start_reg <= first_start_next;
            overflow_reg    <= overflow_next;
        end
    end

    wss_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept && s_tlast),
        .push_data  (result),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_data};

`ifndef SYNTHESIS
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(HAYSTACK_MAX))
        else $error("byte position beyond saturation");

    a_start_only_on_match: assert property (@(posedge aclk) disable iff (!aresetn)
        !match_seen_reg |-> first_start_reg == '0)
        else $error("start index held without a match");

    a_overflow_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> at_max)
        else $error("overflow flag without saturated position");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("last byte accepted but no result request");
`endif

endmodule
